### rtl/core/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Command and status codes, sequencer states and the control group that
// the sequencer broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;

  // fixed field widths on the stream ports
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int IDX_W   = 6;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  // broadcast to all cells during the execute cycle
  typedef struct packed {
    logic             cmp;         // evaluate compare / select flags
    logic             shift_up;    // insert is going ahead
    logic             shift_down;  // delete is going ahead
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
  } skt_ctl_t;

endpackage
`default_nettype wire

### rtl/core/skt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key, compares it against the broadcast key, and takes a key
// from its left or right neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int CELL_IDX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire skt_ctl_t            ctl_i,
  input  wire logic [KEY_BITS-1:0] key_i,      // broadcast key
  input  wire logic                occ_i,      // slot holds a live key
  input  wire logic                left_lt_i,  // left neighbor is below key
  input  wire logic [KEY_BITS-1:0] left_key_i,
  input  wire logic [KEY_BITS-1:0] right_key_i,
  output logic                     lt_o,
  output logic [KEY_BITS-1:0]      key_o,
  output logic                     flag_o
);

  logic [KEY_BITS-1:0] entry_q, entry_d;
  logic                flag_q, flag_d;
  logic                mark;
  logic                at_idx;
  logic                ge_idx;

  assign lt_o   = occ_i && (entry_q < key_i);
  // lower-bound boundary: left neighbor below the key, this one not
  assign mark   = left_lt_i && !lt_o;
  assign at_idx = (CELL_IDX == int'(ctl_i.idx));
  assign ge_idx = (CELL_IDX >= int'(ctl_i.idx));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift_up && !lt_o) begin
      entry_d = left_lt_i ? key_i : left_key_i;
    end else if (ctl_i.shift_down && ge_idx) begin
      entry_d = right_key_i;
    end
  end

  always_comb begin
    flag_d = flag_q;
    if (ctl_i.cmp) begin
      case (ctl_i.cmd)
        CMD_INSERT: flag_d = mark;
        CMD_DELETE: flag_d = at_idx && occ_i;
        CMD_GET:    flag_d = at_idx && occ_i;
        CMD_SEARCH: flag_d = mark && occ_i && (entry_q == key_i);
        default:    flag_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign key_o  = entry_q;
  assign flag_o = flag_q;

endmodule
`default_nettype wire

### rtl/core/skt_result.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_result: result gather for the sorted key chain
// Encodes the one-hot cell flags into a position and ORs out the flagged
// cell's key.
// ----------------------------------------------------------------------------
module skt_result
  import skt_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int PW      = $clog2(DEPTH)
) (
  input  wire logic [DEPTH-1:0]               flags_i,
  input  wire logic [DEPTH-1:0][KEY_BITS-1:0] keys_i,
  output logic                                hit_o,
  output logic [PW-1:0]                       pos_o,
  output logic [KEY_BITS-1:0]                 key_o
);

  always_comb begin
    pos_o = '0;
    key_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (flags_i[i]) begin
        pos_o = pos_o | PW'(i);
        key_o = key_o | keys_i[i];
      end
    end
  end

  assign hit_o = |flags_i;

endmodule
`default_nettype wire

### rtl/core/sorted_key_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key table built as a chain of compare cells
// Keeps up to DEPTH unsigned keys in ascending order.
//
// Input stream (s_axis): one command per transaction: insert key, delete at
// index, get at index, search key. Output stream (m_axis): one result per
// command with status, position, key and the entry count after the command.
// Every cell compares its key against the broadcast key in parallel; an
// insert or delete moves the cells at and above the affected slot by one slot.
// An input transaction passes through the execute step, the cell flag
// registers and the gather step into the result register behind
// m_axis_tvalid. A command is accepted only when the sequencer is idle, so
// the next command waits until the execute and gather steps of the last
// one are through. The result register lets the next command be accepted
// while the previous result still waits; if the receiver stalls longer,
// the sequencer holds in its gather step until the register frees.
// Reset empties the table (count zero) and drops any pending result; key
// storage itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // command [1:0], key [33:2], index [39:34]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status [1:0], position [7:2], item [39:8], entry_count [46:40], zero [47]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  skt_ctl_t ctl;

  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]    idx_q;
  logic                full_q, full_d;
  logic [CW-1:0]       used_q, used_d;

  logic                in_fire;
  logic                out_load;
  logic                is_full;
  logic                del_ok;

  logic [KEY_BITS+KEY_W-1:0] key_wide;
  logic [KEY_BITS-1:0]       key_in;

  logic [DEPTH-1:0]               occ;
  logic [DEPTH-1:0]               lt;
  logic [DEPTH-1:0]               flags;
  logic [DEPTH-1:0][KEY_BITS-1:0] keys;

  logic                hit;
  logic [PW-1:0]       hit_pos;
  logic [KEY_BITS-1:0] hit_key;

  logic [STAT_W-1:0]   res_stat;
  logic [PW-1:0]       res_pos;
  logic [KEY_BITS-1:0] res_key;

  logic [PW+POS_W-1:0]       pos_wide;
  logic [KEY_BITS+KEY_W-1:0] item_wide;
  logic [CW+COUNT_W-1:0]     count_wide;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign key_wide = {{KEY_BITS{1'b0}}, s_axis_tdata[KEY_W+CMD_W-1:CMD_W]};
  assign key_in   = key_wide[KEY_BITS-1:0];

  assign is_full = (used_q == CW'(DEPTH));
  assign del_ok  = ((CW+IDX_W)'(idx_q) < (CW+IDX_W)'(used_q));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_EXEC;
      S_EXEC: state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready  = (state_q == S_IDLE);
    out_load       = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
    ctl.cmp        = (state_q == S_EXEC);
    ctl.shift_up   = (state_q == S_EXEC) && (cmd_e'(cmd_q) == CMD_INSERT) && !is_full;
    ctl.shift_down = (state_q == S_EXEC) && (cmd_e'(cmd_q) == CMD_DELETE) && del_ok;
    ctl.cmd        = cmd_e'(cmd_q);
    ctl.idx        = idx_q;
  end

  always_comb begin
    used_d = used_q;
    full_d = full_q;
    if (state_q == S_EXEC) begin
      full_d = is_full;
      if (ctl.shift_up) begin
        used_d = used_q + CW'(1);
      end else if (ctl.shift_down) begin
        used_d = used_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tdata[CMD_W-1:0];
      key_q <= key_in;
      idx_q <= s_axis_tdata[IDX_W+KEY_W+CMD_W-1:KEY_W+CMD_W];
    end
  end

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                left_lt;
    logic [KEY_BITS-1:0] left_key;
    logic [KEY_BITS-1:0] right_key;

    assign occ[g] = (used_q > CW'(g));

    if (g == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_key = key_q;
    end else begin : g_body
      assign left_lt  = lt[g-1];
      assign left_key = keys[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_key = keys[g];
    end else begin : g_mid
      assign right_key = keys[g+1];
    end

    skt_cell #(
      .KEY_BITS (KEY_BITS),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .key_i       (key_q),
      .occ_i       (occ[g]),
      .left_lt_i   (left_lt),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .lt_o        (lt[g]),
      .key_o       (keys[g]),
      .flag_o      (flags[g])
    );
  end

  skt_result #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_result (
    .flags_i (flags),
    .keys_i  (keys),
    .hit_o   (hit),
    .pos_o   (hit_pos),
    .key_o   (hit_key)
  );

  // ---------------- result formatting ----------------
  always_comb begin
    res_stat = STAT_OK;
    res_pos  = '0;
    res_key  = '0;
    case (cmd_e'(cmd_q))
      CMD_INSERT: begin
        if (full_q) begin
          res_stat = STAT_FULL;
        end else begin
          res_pos = hit_pos;
        end
      end
      CMD_DELETE: begin
        if (!hit) res_stat = STAT_BAD;
      end
      CMD_GET: begin
        if (hit) begin
          res_key = hit_key;
        end else begin
          res_stat = STAT_BAD;
        end
      end
      CMD_SEARCH: begin
        if (hit) begin
          res_pos = hit_pos;
          res_key = hit_key;
        end else begin
          res_stat = STAT_BAD;
        end
      end
      default: res_stat = STAT_BAD;
    endcase
  end

  assign pos_wide   = {{POS_W{1'b0}}, res_pos};
  assign item_wide  = {{KEY_W{1'b0}}, res_key};
  assign count_wide = {{COUNT_W{1'b0}}, used_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {1'b0, count_wide[COUNT_W-1:0], item_wide[KEY_W-1:0],
                     pos_wide[POS_W-1:0], res_stat};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
